FILE: hdl/pid_controller_anti_windup_unit_macros.svh
`ifndef PID_CONTROLLER_ANTI_WINDUP_UNIT_MACROS_SVH
`define PID_CONTROLLER_ANTI_WINDUP_UNIT_MACROS_SVH

// same-cycle property under reset
`define PIDAW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// next-cycle implication under reset
`define PIDAW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error(msg);

`endif

FILE: hdl/pidaw_pkg.sv
package pidaw_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int RW        = 31;
    localparam int MODE_W    = 6;
    localparam int IDX_W     = 3;
    localparam int MAG_W     = 33;
    localparam int SX_W      = 34;
    localparam int QW        = 16;
    localparam int MUL_STEPS = MAG_W;
    localparam int MUL_CNT_W = 6;
    localparam int DIV_CNT_W = 4;

    localparam logic [IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONTROL_MODE   = 3'd5;
    localparam logic [IDX_W-1:0] REG_RATE_SPAN      = 3'd6;
    localparam logic [IDX_W-1:0] REG_RATE_FLOOR     = 3'd7;

    localparam int MODE_DELTA = 0;
    localparam int MODE_TRAP  = 1;
    localparam int MODE_DMEAS = 2;
    localparam int MODE_SEP   = 3;
    localparam int MODE_RATE  = 4;
    localparam int MODE_LIMIT = 5;

    localparam logic [RW-1:0] RATE_RESET = 31'h0001_0000;

    localparam logic signed [SX_W-1:0] S_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [SX_W-1:0] S_MIN = 34'sh3_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_MP_GO, ST_MP_RUN, ST_MI_GO, ST_MI_RUN, ST_MD_GO, ST_MD_RUN,
        ST_OPT, ST_DV_GO, ST_DV_RUN, ST_MF_GO, ST_MF_RUN, ST_LIM, ST_ACC, ST_FIN
    } pidaw_state_t;

    typedef enum logic [1:0] {
        MSEL_P, MSEL_I, MSEL_D, MSEL_F
    } pidaw_msel_t;

    typedef struct packed {
        logic        load;
        logic        pre;
        logic        mul_start;
        pidaw_msel_t msel;
        logic        cap_p;
        logic        cap_i;
        logic        cap_d;
        logic        cap_f;
        logic        opt;
        logic        div_start;
        logic        lim;
        logic        acc;
        logic        fin;
    } pidaw_cmd_t;

    typedef struct packed {
        logic is_reset;
        logic need_div;
        logic mul_done;
        logic div_done;
    } pidaw_status_t;

    function automatic logic signed [SX_W-1:0] sext(input logic [DW-1:0] v);
        return SX_W'(signed'(v));
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [SX_W-1:0] x);
        logic [SX_W-1:0] n;
        n = x[SX_W-1] ? SX_W'(-x) : SX_W'(x);
        return n[MAG_W-1:0];
    endfunction

    function automatic logic [DW-1:0] sat(input logic signed [SX_W-1:0] x);
        logic [DW-1:0] r;
        if (x > S_MAX) begin
            r = S_MAX[DW-1:0];
        end else if (x < S_MIN) begin
            r = S_MIN[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] clamp_abs(input logic signed [SX_W-1:0] x,
                                                input logic [RW-1:0] lim);
        logic signed [SX_W-1:0] lp;
        logic signed [SX_W-1:0] ln;
        logic [DW-1:0] r;
        lp = signed'({3'b000, lim});
        ln = -lp;
        if (x > lp) begin
            r = lp[DW-1:0];
        end else if (x < ln) begin
            r = ln[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/pid_controller_anti_windup_unit.sv
// reset transaction: acceptance, then PRE and FIN, then m_valid
// update transaction: P, I and D products, then a division and one more product when
// the integral rate is scaled; one transaction at a time, with FIN held while m_valid
// is not taken, set by the shared bit-serial multiplier and the 16-step serial divider
// reset: aresetn low clears control, error, integral and feedback state and
// loads the register defaults

module pid_controller_anti_windup_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pidaw_pkg::IDX_W-1:0]        cfg_index,
    input  logic [pidaw_pkg::RW-1:0]           cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic signed [pidaw_pkg::DW-1:0]    s_reference,
    input  logic signed [pidaw_pkg::DW-1:0]    s_feedback,
    input  logic signed [pidaw_pkg::DW-1:0]    s_velocity,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pidaw_pkg::DW-1:0]    m_control_out,
    output logic signed [pidaw_pkg::DW-1:0]    m_integral_out
);

    pidaw_pkg::pidaw_cmd_t    cmd;
    pidaw_pkg::pidaw_status_t status;

    pidaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pidaw_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_mode       (s_mode),
        .s_reference  (s_reference),
        .s_feedback   (s_feedback),
        .s_velocity   (s_velocity),
        .cmd          (cmd),
        .status       (status),
        .control_out  (m_control_out),
        .integral_out (m_integral_out)
    );

endmodule

FILE: hdl/pidaw_mul.sv
module pidaw_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pidaw_pkg::MAG_W-1:0]  a_mag,
    input  logic [pidaw_pkg::MAG_W-1:0]  b_mag,
    input  logic                         neg,
    input  logic                         sh17,
    output logic                         done,
    output logic [pidaw_pkg::DW-1:0]     res
);

    localparam int PW = 2 * pidaw_pkg::MAG_W + 1;
    localparam int HW = pidaw_pkg::MAG_W + 1;
    localparam int QH = 2 * pidaw_pkg::MAG_W - pidaw_pkg::FB;

    logic                             busy_reg;
    logic                             fin_reg;
    logic                             done_reg;
    logic [pidaw_pkg::MUL_CNT_W-1:0]  cnt_reg;
    logic [PW-1:0]                    prod_reg;
    logic [PW-1:0]                    prod_next;
    logic [pidaw_pkg::MAG_W-1:0]      a_reg;
    logic                             neg_reg;
    logic                             sh_reg;
    logic [pidaw_pkg::DW-1:0]         res_reg;
    logic [pidaw_pkg::DW-1:0]         res_next;
    logic [HW-1:0]                    sum;
    logic [QH-1:0]                    qh;
    logic                             ovf;
    logic [pidaw_pkg::DW-1:0]         lowq;

    always_comb begin
        sum = prod_reg[PW-1:pidaw_pkg::MAG_W] + (prod_reg[0] ? {1'b0, a_reg} : HW'(0));
        prod_next = {1'b0, sum, prod_reg[pidaw_pkg::MAG_W-1:1]};
        qh = sh_reg ? {1'b0, prod_reg[PW-2:pidaw_pkg::FB+1]}
                    : prod_reg[PW-2:pidaw_pkg::FB];
        ovf = |qh[QH-1:pidaw_pkg::DW-1];
        lowq = {1'b0, qh[pidaw_pkg::DW-2:0]};
        if (neg_reg) begin
            res_next = ovf ? pidaw_pkg::S_MIN[pidaw_pkg::DW-1:0] : -lowq;
        end else begin
            res_next = ovf ? pidaw_pkg::S_MAX[pidaw_pkg::DW-1:0] : lowq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pidaw_pkg::MUL_CNT_W'(pidaw_pkg::MUL_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= {{(PW - pidaw_pkg::MAG_W){1'b0}}, b_mag};
            a_reg    <= a_mag;
            neg_reg  <= neg;
            sh_reg   <= sh17;
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
        if (fin_reg) begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: hdl/pidaw_div.sv
module pidaw_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [pidaw_pkg::RW-1:0]  rem_in,
    input  logic [pidaw_pkg::RW-1:0]  dvs,
    output logic                      done,
    output logic [pidaw_pkg::QW-1:0]  quo
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [pidaw_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [pidaw_pkg::RW-1:0]         rem_reg;
    logic [pidaw_pkg::RW-1:0]         dvs_reg;
    logic [pidaw_pkg::QW-1:0]         quo_reg;
    logic [pidaw_pkg::RW:0]           r2;
    logic [pidaw_pkg::RW:0]           diff;
    logic                             ge;

    always_comb begin
        r2   = {rem_reg, 1'b0};
        ge   = r2 >= {1'b0, dvs_reg};
        diff = r2 - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pidaw_pkg::DIV_CNT_W'(pidaw_pkg::QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_in;
            dvs_reg <= dvs;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[pidaw_pkg::RW-1:0] : r2[pidaw_pkg::RW-1:0];
            quo_reg <= {quo_reg[pidaw_pkg::QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: hdl/pidaw_dp.sv
module pidaw_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pidaw_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pidaw_pkg::RW-1:0]      cfg_wdata,
    input  logic                          s_mode,
    input  logic signed [pidaw_pkg::DW-1:0] s_reference,
    input  logic signed [pidaw_pkg::DW-1:0] s_feedback,
    input  logic signed [pidaw_pkg::DW-1:0] s_velocity,
    input  pidaw_pkg::pidaw_cmd_t         cmd,
    output pidaw_pkg::pidaw_status_t      status,
    output logic signed [pidaw_pkg::DW-1:0] control_out,
    output logic signed [pidaw_pkg::DW-1:0] integral_out
);

    localparam int DW   = pidaw_pkg::DW;
    localparam int RW   = pidaw_pkg::RW;
    localparam int SX_W = pidaw_pkg::SX_W;

    logic [RW-1:0]                gain_p_reg;
    logic [RW-1:0]                gain_i_reg;
    logic [RW-1:0]                gain_d_reg;
    logic [RW-1:0]                omax_reg;
    logic [RW-1:0]                imax_reg;
    logic [pidaw_pkg::MODE_W-1:0] cmode_reg;
    logic [RW-1:0]                span_reg;
    logic [RW-1:0]                floor_reg;

    logic [DW-1:0] e_now_reg;
    logic [DW-1:0] e_prev_reg;
    logic [DW-1:0] iacc_reg;
    logic [DW-1:0] fbprev_reg;
    logic          mode_reg;
    logic [DW-1:0] ref_reg;
    logic [DW-1:0] fdb_reg;
    logic [DW-1:0] vel_reg;
    logic [DW-1:0] p_reg;
    logic [DW-1:0] inc_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] ctl_reg;
    logic [DW-1:0] int_reg;

    logic signed [SX_W-1:0]        e_sx, ep_sx, ia_sx, inc_sx, p_sx, d_sx, fb_sx, fp_sx, om_sx;
    logic signed [SX_W-1:0]        ti, to, b_sig;
    logic [pidaw_pkg::MAG_W-1:0]   ae, a_op;
    logic                          sh17;
    logic                          same;
    logic [DW-1:0]                 ab;
    logic                          rate_hit, in_range;
    logic [pidaw_pkg::MAG_W-1:0]   rem_full;
    logic                          mul_done, div_done;
    logic [DW-1:0]                 mul_res;
    logic [pidaw_pkg::QW-1:0]      quo;

    always_comb begin
        e_sx   = pidaw_pkg::sext(e_now_reg);
        ep_sx  = pidaw_pkg::sext(e_prev_reg);
        ia_sx  = pidaw_pkg::sext(iacc_reg);
        inc_sx = pidaw_pkg::sext(inc_reg);
        p_sx   = pidaw_pkg::sext(p_reg);
        d_sx   = pidaw_pkg::sext(d_reg);
        fb_sx  = pidaw_pkg::sext(fdb_reg);
        fp_sx  = pidaw_pkg::sext(fbprev_reg);
        om_sx  = signed'({3'b000, omax_reg});
        ae     = pidaw_pkg::mag(e_sx);
        same   = (!e_now_reg[DW-1] && (|e_now_reg) && !iacc_reg[DW-1] && (|iacc_reg))
              || (e_now_reg[DW-1] && iacc_reg[DW-1]);
        ab       = {1'b0, span_reg} + {1'b0, floor_reg};
        rate_hit = cmode_reg[pidaw_pkg::MODE_RATE] && same && (ae > {2'b00, floor_reg});
        in_range = ae <= {1'b0, ab};
        rem_full = {1'b0, ab} - ae;
        ti = ia_sx + inc_sx;
        to = p_sx + ia_sx + d_sx;
    end

    always_comb begin
        sh17 = 1'b0;
        unique case (cmd.msel)
            pidaw_pkg::MSEL_P: begin
                a_op  = {2'b00, gain_p_reg};
                b_sig = e_sx;
            end
            pidaw_pkg::MSEL_I: begin
                a_op  = {2'b00, gain_i_reg};
                sh17  = cmode_reg[pidaw_pkg::MODE_TRAP];
                b_sig = cmode_reg[pidaw_pkg::MODE_TRAP] ? e_sx + ep_sx : e_sx;
            end
            pidaw_pkg::MSEL_D: begin
                a_op = {2'b00, gain_d_reg};
                if (cmode_reg[pidaw_pkg::MODE_DMEAS]) begin
                    b_sig = fp_sx - fb_sx;
                end else if (cmode_reg[pidaw_pkg::MODE_DELTA]) begin
                    b_sig = pidaw_pkg::sext(vel_reg);
                end else begin
                    b_sig = e_sx - ep_sx;
                end
            end
            pidaw_pkg::MSEL_F: begin
                a_op  = {{(pidaw_pkg::MAG_W - pidaw_pkg::QW){1'b0}}, quo};
                b_sig = inc_sx;
            end
            default: begin
                a_op  = '0;
                b_sig = '0;
            end
        endcase
    end

    pidaw_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_mag   (a_op),
        .b_mag   (pidaw_pkg::mag(b_sig)),
        .neg     (b_sig[SX_W-1]),
        .sh17    (sh17),
        .done    (mul_done),
        .res     (mul_res)
    );

    pidaw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .rem_in  (rem_full[RW-1:0]),
        .dvs     (span_reg),
        .done    (div_done),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            omax_reg   <= '0;
            imax_reg   <= '0;
            cmode_reg  <= '0;
            span_reg   <= pidaw_pkg::RATE_RESET;
            floor_reg  <= pidaw_pkg::RATE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidaw_pkg::REG_GAIN_P:         gain_p_reg <= cfg_wdata;
                pidaw_pkg::REG_GAIN_I:         gain_i_reg <= cfg_wdata;
                pidaw_pkg::REG_GAIN_D:         gain_d_reg <= cfg_wdata;
                pidaw_pkg::REG_OUTPUT_LIMIT:   omax_reg   <= cfg_wdata;
                pidaw_pkg::REG_INTEGRAL_LIMIT: imax_reg   <= cfg_wdata;
                pidaw_pkg::REG_CONTROL_MODE:   cmode_reg  <= cfg_wdata[pidaw_pkg::MODE_W-1:0];
                pidaw_pkg::REG_RATE_SPAN:      span_reg   <= cfg_wdata;
                pidaw_pkg::REG_RATE_FLOOR:     floor_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_now_reg  <= '0;
            e_prev_reg <= '0;
            iacc_reg   <= '0;
            fbprev_reg <= '0;
        end else begin
            if (cmd.pre) begin
                if (mode_reg) begin
                    e_now_reg  <= '0;
                    e_prev_reg <= '0;
                    iacc_reg   <= '0;
                    fbprev_reg <= fdb_reg;
                end else begin
                    e_prev_reg <= e_now_reg;
                    e_now_reg  <= pidaw_pkg::sat(pidaw_pkg::sext(ref_reg) - fb_sx);
                end
            end
            if (cmd.lim && cmode_reg[pidaw_pkg::MODE_LIMIT]) begin
                if (ti > signed'({3'b000, imax_reg})) begin
                    iacc_reg <= {1'b0, imax_reg};
                end else if (ti < -signed'({3'b000, imax_reg})) begin
                    iacc_reg <= -{1'b0, imax_reg};
                end
            end
            if (cmd.acc) begin
                iacc_reg <= pidaw_pkg::clamp_abs(ia_sx + inc_sx, imax_reg);
            end
            if (cmd.fin && !mode_reg) begin
                fbprev_reg <= fdb_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_mode;
            ref_reg  <= s_reference;
            fdb_reg  <= s_feedback;
            vel_reg  <= s_velocity;
        end
        if (cmd.cap_p) begin
            p_reg <= mul_res;
        end
        if (cmd.cap_d) begin
            d_reg <= mul_res;
        end
        if (cmd.cap_i || cmd.cap_f) begin
            inc_reg <= mul_res;
        end
        if (cmd.opt) begin
            if ((cmode_reg[pidaw_pkg::MODE_SEP] && same && (ae > {2'b00, omax_reg}))
                || (rate_hit && !in_range)) begin
                inc_reg <= '0;
            end
        end
        if (cmd.lim && cmode_reg[pidaw_pkg::MODE_LIMIT]) begin
            if ((((to > om_sx) || (to < -om_sx)) && same)
                || (ti > signed'({3'b000, imax_reg}))
                || (ti < -signed'({3'b000, imax_reg}))) begin
                inc_reg <= '0;
            end
        end
        if (cmd.fin) begin
            if (mode_reg) begin
                ctl_reg <= '0;
                int_reg <= '0;
            end else begin
                ctl_reg <= pidaw_pkg::clamp_abs(p_sx + ia_sx + d_sx, omax_reg);
                int_reg <= iacc_reg;
            end
        end
    end

    always_comb begin
        status.is_reset = mode_reg;
        status.need_div = rate_hit && in_range;
        status.mul_done = mul_done;
        status.div_done = div_done;
    end

    assign control_out  = ctl_reg;
    assign integral_out = int_reg;

endmodule

FILE: hdl/pidaw_ctrl.sv
`include "pid_controller_anti_windup_unit_macros.svh"

module pidaw_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  pidaw_pkg::pidaw_status_t  status,
    output pidaw_pkg::pidaw_cmd_t     cmd
);

    pidaw_pkg::pidaw_state_t state_reg;
    pidaw_pkg::pidaw_state_t state_next;
    logic                    m_valid_reg;
    logic                    out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE:   if (s_valid) state_next = pidaw_pkg::ST_PRE;
            pidaw_pkg::ST_PRE:    state_next = status.is_reset ? pidaw_pkg::ST_FIN
                                                               : pidaw_pkg::ST_MP_GO;
            pidaw_pkg::ST_MP_GO:  state_next = pidaw_pkg::ST_MP_RUN;
            pidaw_pkg::ST_MP_RUN: if (status.mul_done) state_next = pidaw_pkg::ST_MI_GO;
            pidaw_pkg::ST_MI_GO:  state_next = pidaw_pkg::ST_MI_RUN;
            pidaw_pkg::ST_MI_RUN: if (status.mul_done) state_next = pidaw_pkg::ST_MD_GO;
            pidaw_pkg::ST_MD_GO:  state_next = pidaw_pkg::ST_MD_RUN;
            pidaw_pkg::ST_MD_RUN: if (status.mul_done) state_next = pidaw_pkg::ST_OPT;
            pidaw_pkg::ST_OPT:    state_next = status.need_div ? pidaw_pkg::ST_DV_GO
                                                               : pidaw_pkg::ST_LIM;
            pidaw_pkg::ST_DV_GO:  state_next = pidaw_pkg::ST_DV_RUN;
            pidaw_pkg::ST_DV_RUN: if (status.div_done) state_next = pidaw_pkg::ST_MF_GO;
            pidaw_pkg::ST_MF_GO:  state_next = pidaw_pkg::ST_MF_RUN;
            pidaw_pkg::ST_MF_RUN: if (status.mul_done) state_next = pidaw_pkg::ST_LIM;
            pidaw_pkg::ST_LIM:    state_next = pidaw_pkg::ST_ACC;
            pidaw_pkg::ST_ACC:    state_next = pidaw_pkg::ST_FIN;
            pidaw_pkg::ST_FIN:    if (out_free) state_next = pidaw_pkg::ST_IDLE;
            default:              state_next = pidaw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pidaw_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            pidaw_pkg::ST_PRE: cmd.pre = 1'b1;
            pidaw_pkg::ST_MP_GO: begin
                cmd.mul_start = 1'b1;
                cmd.msel      = pidaw_pkg::MSEL_P;
            end
            pidaw_pkg::ST_MP_RUN: begin
                cmd.msel  = pidaw_pkg::MSEL_P;
                cmd.cap_p = status.mul_done;
            end
            pidaw_pkg::ST_MI_GO: begin
                cmd.mul_start = 1'b1;
                cmd.msel      = pidaw_pkg::MSEL_I;
            end
            pidaw_pkg::ST_MI_RUN: begin
                cmd.msel  = pidaw_pkg::MSEL_I;
                cmd.cap_i = status.mul_done;
            end
            pidaw_pkg::ST_MD_GO: begin
                cmd.mul_start = 1'b1;
                cmd.msel      = pidaw_pkg::MSEL_D;
            end
            pidaw_pkg::ST_MD_RUN: begin
                cmd.msel  = pidaw_pkg::MSEL_D;
                cmd.cap_d = status.mul_done;
            end
            pidaw_pkg::ST_OPT:    cmd.opt = 1'b1;
            pidaw_pkg::ST_DV_GO:  cmd.div_start = 1'b1;
            pidaw_pkg::ST_DV_RUN: cmd.msel = pidaw_pkg::MSEL_F;
            pidaw_pkg::ST_MF_GO: begin
                cmd.mul_start = 1'b1;
                cmd.msel      = pidaw_pkg::MSEL_F;
            end
            pidaw_pkg::ST_MF_RUN: begin
                cmd.msel  = pidaw_pkg::MSEL_F;
                cmd.cap_f = status.mul_done;
            end
            pidaw_pkg::ST_LIM: cmd.lim = 1'b1;
            pidaw_pkg::ST_ACC: cmd.acc = 1'b1;
            pidaw_pkg::ST_FIN: cmd.fin = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pidaw_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    `PIDAW_ASSERT(a_fin_free, aclk, aresetn, cmd.fin |-> (!m_valid_reg || m_ready), "result overwritten")
    `PIDAW_ASSERT(a_mul_done_run, aclk, aresetn, status.mul_done |-> (state_reg == pidaw_pkg::ST_MP_RUN || state_reg == pidaw_pkg::ST_MI_RUN || state_reg == pidaw_pkg::ST_MD_RUN || state_reg == pidaw_pkg::ST_MF_RUN), "multiplier done outside run state")
    `PIDAW_ASSERT(a_div_done_run, aclk, aresetn, status.div_done |-> (state_reg == pidaw_pkg::ST_DV_RUN), "divider done outside run state")
    `PIDAW_ASSERT_NEXT(a_fin_valid, aclk, aresetn, cmd.fin, m_valid_reg, "result not presented")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 400;
    localparam longint VMAX    = 64'sd2147483647;
    localparam longint VMIN    = -64'sd2147483648;

    typedef struct {
        logic              is_reset;
        logic signed [31:0] setpoint;
        logic signed [31:0] meas;
        logic signed [31:0] rate;
    } pid_item_t;

    typedef struct {
        logic signed [31:0] drive;
        logic signed [31:0] integ;
    } pid_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [pidaw_pkg::IDX_W-1:0] cfg_index = '0;
    logic [pidaw_pkg::RW-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic signed [pidaw_pkg::DW-1:0] s_reference = '0;
    logic signed [pidaw_pkg::DW-1:0] s_feedback = '0;
    logic signed [pidaw_pkg::DW-1:0] s_velocity = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [pidaw_pkg::DW-1:0] m_control_out;
    logic signed [pidaw_pkg::DW-1:0] m_integral_out;

    pid_controller_anti_windup_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_reference(s_reference), .s_feedback(s_feedback), .s_velocity(s_velocity),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_control_out(m_control_out), .m_integral_out(m_integral_out)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // controller settings and state as the predictor sees them
    logic [pidaw_pkg::RW-1:0] kp, ki, kd, olim, ilim, span, floor_v;
    logic [pidaw_pkg::MODE_W-1:0] ctl_mode;
    longint err_now, err_prev, integ_acc, fb_prev;

    pid_item_t   pending_q[$];
    pid_result_t result_q[$];
    pid_item_t   cur_item;
    int fails = 0;
    int cycles = 0;
    int src_gap = 0;
    int snk_stall = 0;
    int hold_cnt = 0;
    bit hold_req = 0;
    bit calm = 0;

    function automatic longint sat_val(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    function automatic longint clamp_lim(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    // exact magnitude product, truncating shift, signed saturation
    function automatic longint q_mul(longint a, longint b, int sh);
        logic [63:0] ua, ub;
        logic [127:0] q;
        bit neg;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        q = ({64'd0, ua} * {64'd0, ub}) >> sh;
        if (neg) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            return -longint'(q[63:0]);
        end
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return longint'(q[63:0]);
    endfunction

    function automatic pid_result_t pid_predict(pid_item_t it);
        pid_result_t r;
        longint e, p, inc, d, ae, iacc, ti, tot, a, b, f, fdb, omax, imax;
        bit same;
        fdb = longint'(it.meas);
        omax = longint'(olim);
        imax = longint'(ilim);
        if (it.is_reset) begin
            err_now = 0;
            err_prev = 0;
            integ_acc = 0;
            fb_prev = fdb;
            r.drive = '0;
            r.integ = '0;
            return r;
        end
        err_prev = err_now;
        e = sat_val(longint'(it.setpoint) - fdb);
        err_now = e;
        ae = (e < 0) ? -e : e;
        iacc = integ_acc;
        same = (e > 0 && iacc > 0) || (e < 0 && iacc < 0);
        p = q_mul(longint'(kp), e, pidaw_pkg::FB);
        inc = q_mul(longint'(ki), e, pidaw_pkg::FB);
        if (ctl_mode[pidaw_pkg::MODE_DELTA]) begin
            d = q_mul(longint'(kd), longint'(it.rate), pidaw_pkg::FB);
        end else begin
            d = q_mul(longint'(kd), e - err_prev, pidaw_pkg::FB);
        end
        if (ctl_mode[pidaw_pkg::MODE_TRAP]) begin
            inc = q_mul(longint'(ki), e + err_prev, pidaw_pkg::FB + 1);
        end
        if (ctl_mode[pidaw_pkg::MODE_DMEAS]) begin
            d = q_mul(longint'(kd), fb_prev - fdb, pidaw_pkg::FB);
        end
        if (ctl_mode[pidaw_pkg::MODE_SEP] && same && ae > omax) inc = 0;
        if (ctl_mode[pidaw_pkg::MODE_RATE] && same && ae > longint'(floor_v)) begin
            a = longint'(span);
            b = longint'(floor_v);
            if (ae <= a + b && a != 0) begin
                f = longint'((64'(a + b - ae) << pidaw_pkg::FB) / 64'(a));
                inc = q_mul(inc, f, pidaw_pkg::FB);
            end else begin
                inc = 0;
            end
        end
        if (ctl_mode[pidaw_pkg::MODE_LIMIT]) begin
            ti = iacc + inc;
            tot = p + iacc + d;
            if ((tot > omax || tot < -omax) && same) inc = 0;
            if (ti > imax) begin
                inc = 0;
                iacc = imax;
            end
            if (ti < -imax) begin
                inc = 0;
                iacc = -imax;
            end
        end
        iacc = sat_val(clamp_lim(iacc + inc, imax));
        integ_acc = iacc;
        fb_prev = fdb;
        r.drive = 32'(sat_val(clamp_lim(p + iacc + d, omax)));
        r.integ = 32'(iacc);
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            automatic bit acc = s_valid && s_ready;
            automatic bit nv = s_valid && !acc;
            if (acc) result_q.push_back(pid_predict(cur_item));
            if (!nv) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_q.size() > 0) begin
                    if (!calm && $urandom_range(0, 3) == 0) begin
                        src_gap = $urandom_range(0, 4);
                    end else begin
                        cur_item = pending_q.pop_front();
                        s_mode <= cur_item.is_reset;
                        s_reference <= cur_item.setpoint;
                        s_feedback <= cur_item.meas;
                        s_velocity <= cur_item.rate;
                        nv = 1;
                    end
                end
            end
            s_valid <= nv;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fails++;
                end else begin
                    automatic pid_result_t want = result_q.pop_front();
                    if (m_control_out !== want.drive) begin
                        $error("control_out expected %0d actual %0d", want.drive,
                               m_control_out);
                        fails++;
                    end
                    if (m_integral_out !== want.integ) begin
                        $error("integral_out expected %0d actual %0d", want.integ,
                               m_integral_out);
                        fails++;
                    end
                end
            end
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (snk_stall > 0) begin
                snk_stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                snk_stall = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pid_controller_anti_windup_unit verification failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [pidaw_pkg::IDX_W-1:0] idx, logic [pidaw_pkg::RW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pidaw_pkg::REG_GAIN_P:         kp = val;
            pidaw_pkg::REG_GAIN_I:         ki = val;
            pidaw_pkg::REG_GAIN_D:         kd = val;
            pidaw_pkg::REG_OUTPUT_LIMIT:   olim = val;
            pidaw_pkg::REG_INTEGRAL_LIMIT: ilim = val;
            pidaw_pkg::REG_CONTROL_MODE:   ctl_mode = val[pidaw_pkg::MODE_W-1:0];
            pidaw_pkg::REG_RATE_SPAN:      span = val;
            pidaw_pkg::REG_RATE_FLOOR:     floor_v = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic cfg_all(logic [pidaw_pkg::RW-1:0] p, logic [pidaw_pkg::RW-1:0] i,
                           logic [pidaw_pkg::RW-1:0] d, logic [pidaw_pkg::RW-1:0] ol,
                           logic [pidaw_pkg::RW-1:0] il, logic [pidaw_pkg::RW-1:0] md,
                           logic [pidaw_pkg::RW-1:0] sp, logic [pidaw_pkg::RW-1:0] fl);
        cfg_write(pidaw_pkg::REG_GAIN_P, p);
        cfg_write(pidaw_pkg::REG_GAIN_I, i);
        cfg_write(pidaw_pkg::REG_GAIN_D, d);
        cfg_write(pidaw_pkg::REG_OUTPUT_LIMIT, ol);
        cfg_write(pidaw_pkg::REG_INTEGRAL_LIMIT, il);
        cfg_write(pidaw_pkg::REG_CONTROL_MODE, md);
        cfg_write(pidaw_pkg::REG_RATE_SPAN, sp);
        cfg_write(pidaw_pkg::REG_RATE_FLOOR, fl);
    endtask

    // sampled after the edge so that driver and monitor updates have settled
    task automatic wait_idle();
        @(posedge aclk);
        #1;
        while (pending_q.size() != 0 || s_valid || result_q.size() != 0) begin
            @(posedge aclk);
            #1;
        end
    endtask

    function automatic logic [pidaw_pkg::RW-1:0] rnd_val(int small_max);
        if ($urandom_range(0, 3) == 0) return pidaw_pkg::RW'($urandom);
        return pidaw_pkg::RW'($urandom_range(0, small_max));
    endfunction

    function automatic logic signed [31:0] rnd_small();
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    function automatic pid_item_t mk(logic r, logic signed [31:0] sp,
                                     logic signed [31:0] fb, logic signed [31:0] v);
        pid_item_t it;
        it.is_reset = r;
        it.setpoint = sp;
        it.meas = fb;
        it.rate = v;
        return it;
    endfunction

    function automatic pid_item_t rnd_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return mk(1'b1, $urandom, $urandom, $urandom);
        if (r < 15) return mk(1'b0, $urandom, $urandom, $urandom);
        return mk(1'b0, rnd_small(), rnd_small(),
                  ($urandom_range(0, 1) == 0) ? rnd_small() : $signed($urandom));
    endfunction

    task automatic push_directed();
        pending_q.push_back(mk(1'b1, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0));
        pending_q.push_back(mk(1'b0, 32'sh0, 32'sh0, 32'sh0));
        pending_q.push_back(mk(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_q.push_back(mk(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
        pending_q.push_back(mk(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
        pending_q.push_back(mk(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF));
        pending_q.push_back(mk(1'b0, 32'sh0002_0000, 32'sh0, 32'sh0001_0000));
        pending_q.push_back(mk(1'b0, 32'sh0002_0000, 32'sh0, 32'shFFFF_0000));
        pending_q.push_back(mk(1'b0, 32'sh0001_8000, 32'sh0, 32'sh0));
        pending_q.push_back(mk(1'b0, 32'shFFFE_0000, 32'sh0, 32'sh0));
        pending_q.push_back(mk(1'b1, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF));
        pending_q.push_back(mk(1'b0, 32'sh0, 32'sh0000_0001, 32'sh0));
    endtask

    initial begin
        kp = '0; ki = '0; kd = '0; olim = '0; ilim = '0; ctl_mode = '0;
        span = pidaw_pkg::RATE_RESET;
        floor_v = pidaw_pkg::RATE_RESET;
        err_now = 0; err_prev = 0; integ_acc = 0; fb_prev = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // defaults, all gains zero
        pending_q.push_back(mk(1'b0, 32'sh0003_0000, 32'sh0, 32'sh0));
        wait_idle();
        cfg_all(31'h0001_8000, 31'h0000_8000, 31'h0002_0000, 31'h0010_0000,
                31'h0004_0000, 31'h0, 31'h0001_0000, 31'h0001_0000);
        push_directed();
        wait_idle();
        cfg_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                31'h7FFF_FFFF, 31'h3F, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_directed();
        wait_idle();
        cfg_all(31'h0001_0000, 31'h0002_0000, 31'h0000_4000, 31'h0003_0000,
                31'h0002_0000, 31'h3E, 31'h0000_0001, 31'h0);
        push_directed();

        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            if (ph == 0) begin
                cfg_all('0, '0, '0, '0, '0, 31'h01, 31'h0000_0001, '0);
            end else begin
                cfg_all(rnd_val(3 << 16), rnd_val(3 << 16), rnd_val(3 << 16),
                        rnd_val(8 << 16), rnd_val(8 << 16),
                        pidaw_pkg::RW'($urandom_range(0, 63)),
                        ($urandom_range(0, 3) == 0)
                            ? pidaw_pkg::RW'($urandom_range(1, 32'h7FFF_FFFF))
                            : pidaw_pkg::RW'($urandom_range(1, 4 << 16)),
                        rnd_val(4 << 16));
            end
            if (ph == 9) calm = 1;
            for (int k = 0; k < 86; k++) pending_q.push_back(rnd_item());
            if (ph == 4) hold_req = 1;
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        if (fails == 0) begin
            $display("pid_controller_anti_windup_unit verification clean");
        end else begin
            $display("pid_controller_anti_windup_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pidaw_pkg.sv
hdl/pidaw_mul.sv
hdl/pidaw_div.sv
hdl/pidaw_dp.sv
hdl/pidaw_ctrl.sv
hdl/pid_controller_anti_windup_unit.sv
sim/testbench.sv
